// ===== rtl/mtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg: shared types and constants of the missing-tooth gap decoder
// Field widths, queue geometry and the command beat passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int TS_W        = 32;
	localparam int DUR_W       = 15;
	localparam int IDX_W       = 8;
	localparam int HIST_D      = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DUR_W-1:0] MAX_DUR_RESET = {DUR_W{1'b1}};
	localparam logic [IDX_W-1:0] IDX_MAX       = {IDX_W{1'b1}};

	// what the back end has to do with a queued beat
	typedef enum logic {
		CMD_CLEAR = 1'b0,
		CMD_PUSH  = 1'b1
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t           code;
		logic [DUR_W-1:0]    dur;
		logic [TS_W-1:0]     ts;
	} cmd_entry_t;

endpackage

// ===== rtl/mtg_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg channel interfaces
// Valid/ready channels for sensor samples, decoded edges and the
// configuration write.
// ----------------------------------------------------------------------------
interface mtg_sample_if;
	logic                      valid;
	logic                      ready;
	logic [mtg_pkg::TS_W-1:0]  timestamp;
	logic                      level;
	modport source (output valid, timestamp, level, input ready);
	modport sink   (input valid, timestamp, level, output ready);
endinterface

interface mtg_edge_if;
	logic                      valid;
	logic                      ready;
	logic [mtg_pkg::IDX_W-1:0] edge_index;
	logic [mtg_pkg::TS_W-1:0]  edge_time;
	modport source (output valid, edge_index, edge_time, input ready);
	modport sink   (input valid, edge_index, edge_time, output ready);
endinterface

interface mtg_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [mtg_pkg::DUR_W-1:0] max_duration;
	modport source (output valid, max_duration, input ready);
	modport sink   (input valid, max_duration, output ready);
endinterface

// ===== rtl/mtg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_front: sample intake and segment classification
// Tracks the sensor level, measures segment durations and queues either a
// history push or a full clear for the back end.
// ----------------------------------------------------------------------------
module mtg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	mtg_sample_if.sink           samples,
	mtg_cfg_if.sink              cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output mtg_pkg::cmd_entry_t  push_entry
);
	import mtg_pkg::*;

	logic              level_known_q;
	logic              last_level_q;
	logic [TS_W-1:0]   last_time_q;
	logic [DUR_W-1:0]  max_dur_q;

	logic [TS_W-1:0]   dur_full;
	logic              accept;
	logic              is_change;
	logic              bad_dur;

	// config register; the user writes it only while idle, the block itself does not enforce this
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dur_q <= MAX_DUR_RESET;
		end else if (cfg.valid) begin
			max_dur_q <= cfg.max_duration;
		end
	end

	// classification of the incoming beat
	assign samples.ready = push_ready;
	assign accept        = samples.valid & push_ready;
	assign dur_full      = samples.timestamp - last_time_q;
	assign is_change     = level_known_q && (samples.level != last_level_q);
	assign bad_dur       = (dur_full == '0) ||
	                       (dur_full >= {{(TS_W-DUR_W){1'b0}}, max_dur_q});

	assign push_valid       = accept && is_change;
	assign push_entry.code  = bad_dur ? CMD_CLEAR : CMD_PUSH;
	assign push_entry.dur   = dur_full[DUR_W-1:0];
	assign push_entry.ts    = samples.timestamp;

	// level tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_known_q <= 1'b0;
			last_level_q  <= 1'b0;
			last_time_q   <= '0;
		end else if (accept) begin
			if (!level_known_q) begin
				level_known_q <= 1'b1;
				last_level_q  <= samples.level;
				last_time_q   <= samples.timestamp;
			end else if (is_change) begin
				if (bad_dur) begin
					level_known_q <= 1'b0;
					last_level_q  <= 1'b0;
					last_time_q   <= '0;
				end else begin
					last_level_q  <= samples.level;
					last_time_q   <= samples.timestamp;
				end
			end
		end
	end

endmodule

// ===== rtl/mtg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_queue: short command queue between front and back end
// Circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mtg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  mtg_pkg::cmd_entry_t  push_entry,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output mtg_pkg::cmd_entry_t  pop_entry
);
	import mtg_pkg::*;

	cmd_entry_t         slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slots_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mtg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_back: duration history, gap test and edge numbering
// Executes queued commands and holds the result in an output register.
// ----------------------------------------------------------------------------
module mtg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  mtg_pkg::cmd_entry_t  pop_entry,
	mtg_edge_if.source           edges
);
	import mtg_pkg::*;

	logic [DUR_W-1:0]  hist_q [HIST_D];
	logic              synced_q;
	logic [IDX_W-1:0]  count_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [TS_W-1:0]   out_time_q;

	logic              do_pop;
	logic [DUR_W-1:0]  nh0, nh1, nh2, nh3;
	logic [DUR_W:0]    pair_sum;
	logic [DUR_W-1:0]  mean;
	logic [DUR_W-1:0]  diff;
	logic [DUR_W:0]    twice_mean;
	logic              gap;
	logic              full;
	logic [IDX_W-1:0]  next_count;
	logic              emit;

	assign pop_ready = !out_valid_q || edges.ready;
	assign do_pop    = pop_valid && pop_ready;

	// history as it stands after this push
	assign nh0 = pop_entry.dur;
	assign nh1 = hist_q[0];
	assign nh2 = hist_q[1];
	assign nh3 = hist_q[2];
	assign full = (nh3 != '0);

	// gap test: older pair agrees within an eighth, newer pair at least twice
	assign pair_sum   = {1'b0, nh2} + {1'b0, nh3};
	assign mean       = pair_sum[DUR_W:1];
	assign diff       = (nh2 >= nh3) ? (nh2 - nh3) : (nh3 - nh2);
	assign twice_mean = {mean, 1'b0};
	assign gap        = (diff < (mean >> 3)) &&
	                    ({1'b0, nh0} >= twice_mean) && ({1'b0, nh1} >= twice_mean);

	assign next_count = gap ? '0 : ((count_q == IDX_MAX) ? count_q : count_q + 1'b1);
	assign emit       = do_pop && (pop_entry.code == CMD_PUSH) && full && (gap || synced_q);

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_D; i++) begin
				hist_q[i] <= '0;
			end
			synced_q <= 1'b0;
			count_q  <= '0;
		end else if (do_pop) begin
			unique case (pop_entry.code)
				CMD_CLEAR: begin
					for (int i = 0; i < HIST_D; i++) begin
						hist_q[i] <= '0;
					end
					synced_q <= 1'b0;
					count_q  <= '0;
				end
				CMD_PUSH: begin
					hist_q[0] <= nh0;
					for (int i = 1; i < HIST_D; i++) begin
						hist_q[i] <= hist_q[i-1];
					end
					if (full && (gap || synced_q)) begin
						synced_q <= 1'b1;
						count_q  <= next_count;
					end
				end
				default: begin
					synced_q <= synced_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (edges.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_index_q <= next_count;
			out_time_q  <= pop_entry.ts;
		end
	end

	assign edges.valid      = out_valid_q;
	assign edges.edge_index = out_index_q;
	assign edges.edge_time  = out_time_q;

endmodule

// ===== rtl/missing_tooth_gap_edge_decoder.sv =====
`timescale 1ns / 1ps
// Path: an accepted sample writes the command queue, and a popped command
//   loads the output register, waiting while that register holds an undrained beat.
// Throughput: one sample per cycle while the queue has room; the back end retires
//   one queued command per cycle whenever its output register is free or being drained.
// Reset: arst_n clears tracking state, queue and output valid at once;
//   max_duration returns to 32767. No clearing pass is needed.
// ----------------------------------------------------------------------------
// missing_tooth_gap_edge_decoder: crank wheel gap and edge decoder
// Front end measures segments, a two-entry queue decouples it from the
// back end that finds the missing-tooth gap and numbers the edges.
// ----------------------------------------------------------------------------
module missing_tooth_gap_edge_decoder (
	input  logic        clk,
	input  logic        arst_n,
	mtg_sample_if.sink  samples,
	mtg_cfg_if.sink     cfg,
	mtg_edge_if.source  edges
);
	import mtg_pkg::*;

	logic        push_valid;
	logic        push_ready;
	cmd_entry_t  push_entry;
	logic        pop_valid;
	logic        pop_ready;
	cmd_entry_t  pop_entry;

	mtg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	mtg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	mtg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.edges      (edges)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for missing_tooth_gap_edge_decoder
// Feeds timestamped crank levels (directed corner cases, then synthetic
// tooth wheels with missing-tooth gaps, noise, zero and too-long segments).
// A scoreboard tracks the wheel state on its own and checks every edge beat
// in order, across several max_duration settings.
// ----------------------------------------------------------------------------
module tb;
	import mtg_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 200;

	typedef struct packed {
		logic [IDX_W-1:0] edge_index;
		logic [TS_W-1:0]  edge_time;
	} edge_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks wheel state per accepted sample, queues edge beats
	// ------------------------------------------------------------------------
	class crank_edge_scoreboard;
		logic [DUR_W-1:0] max_dur;
		bit               level_known;
		logic             last_level;
		logic [TS_W-1:0]  last_change_ts;
		logic [DUR_W-1:0] seg_hist [HIST_D];
		bit               synced;
		logic [IDX_W-1:0] seg_count;
		edge_beat_t       expected_edges [$];
		int               errors;

		function new();
			max_dur = MAX_DUR_RESET;
			errors  = 0;
			clear_tracking();
		endfunction

		function void clear_tracking();
			level_known    = 1'b0;
			last_level     = 1'b0;
			last_change_ts = '0;
			foreach (seg_hist[i]) seg_hist[i] = '0;
			synced         = 1'b0;
			seg_count      = '0;
		endfunction

		function void set_max_duration(input logic [DUR_W-1:0] value);
			max_dur = value;
		endfunction

		function int pending();
			return expected_edges.size();
		endfunction

		// older pair agrees within an eighth of its mean, newer pair at least twice it
		function bit gap_found();
			logic [31:0] mean;
			logic [31:0] diff;
			mean = ({17'd0, seg_hist[2]} + {17'd0, seg_hist[3]}) >> 1;
			diff = (seg_hist[2] >= seg_hist[3]) ? {17'd0, seg_hist[2] - seg_hist[3]}
				: {17'd0, seg_hist[3] - seg_hist[2]};
			if (diff >= (mean >> 3))
				return 1'b0;
			if ({17'd0, seg_hist[0]} < 2 * mean || {17'd0, seg_hist[1]} < 2 * mean)
				return 1'b0;
			return 1'b1;
		endfunction

		function void track_sample(input logic [TS_W-1:0] ts, input logic lvl);
			logic [TS_W-1:0] dur;
			edge_beat_t      beat;
			if (!level_known) begin
				level_known    = 1'b1;
				last_level     = lvl;
				last_change_ts = ts;
				return;
			end
			if (lvl == last_level)
				return;
			dur = ts - last_change_ts;
			// zero or too-long segment drops everything, sample not recorded
			if (dur == 0 || dur >= {17'd0, max_dur}) begin
				clear_tracking();
				return;
			end
			last_level     = lvl;
			last_change_ts = ts;
			for (int i = HIST_D - 1; i > 0; i--)
				seg_hist[i] = seg_hist[i-1];
			seg_hist[0] = dur[DUR_W-1:0];
			if (seg_hist[HIST_D-1] == 0)
				return;
			if (gap_found()) begin
				synced    = 1'b1;
				seg_count = '0;
			end else begin
				if (!synced)
					return;
				if (seg_count != IDX_MAX)
					seg_count++;
			end
			beat.edge_index = seg_count;
			beat.edge_time  = ts;
			expected_edges.push_back(beat);
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_edge(input logic [IDX_W-1:0] idx, input logic [TS_W-1:0] t);
			edge_beat_t want;
			if (expected_edges.size() == 0) begin
				report_mismatch($sformatf("unexpected edge index %0d time %h", idx, t));
				return;
			end
			want = expected_edges.pop_front();
			if (idx !== want.edge_index)
				report_mismatch($sformatf("edge_index got %0d want %0d (time %h)",
					idx, want.edge_index, want.edge_time));
			if (t !== want.edge_time)
				report_mismatch($sformatf("edge_time got %h want %h", t, want.edge_time));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   no_idling;
	bit   hold_req;
	logic [DUR_W-1:0] cur_max_dur;

	crank_edge_scoreboard sb = new();

	mtg_sample_if samples_if();
	mtg_edge_if   edges_if();
	mtg_cfg_if    cfg_if();

	missing_tooth_gap_edge_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.cfg    (cfg_if),
		.edges  (edges_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sample driver tasks
	// ------------------------------------------------------------------------
	task automatic send_sample(input logic [TS_W-1:0] ts, input logic lvl);
		int unsigned gap_len;
		if (!no_idling && $urandom_range(0, 5) == 0) begin
			gap_len = $urandom_range(1, 18);
			samples_if.valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.timestamp <= ts;
		samples_if.level     <= lvl;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		sb.track_sample(ts, lvl);
	endtask

	// advance time by one segment and flip the level
	task automatic toggle_level(inout logic [TS_W-1:0] t, inout logic lvl,
		input logic [TS_W-1:0] dur);
		t   = t + dur;
		lvl = ~lvl;
		send_sample(t, lvl);
	endtask

	// let every outstanding edge drain before touching the register
	task automatic drain_block();
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_duration(input logic [DUR_W-1:0] value);
		cfg_if.valid        <= 1'b1;
		cfg_if.max_duration <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.set_max_duration(value);
		cur_max_dur = value;
	endtask

	// mostly tooth wheels with a two-segment gap, plus broken gaps and noise
	task automatic run_phase(input int n_changes, input bit long_wheel);
		logic [TS_W-1:0] t;
		logic            lvl;
		logic [TS_W-1:0] dur;
		int              sent;
		int              seq;
		int unsigned     kind;
		int unsigned     base;
		int unsigned     jit;
		int              teeth;
		int              gap_segs;
		t    = $urandom();
		lvl  = 1'($urandom_range(0, 1));
		sent = 0;
		seq  = 0;
		send_sample(t, lvl);
		while (sent < n_changes) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				if (cur_max_dur >= 40)
					base = $urandom_range(0, 3) == 0 ? $urandom_range(4, cur_max_dur / 4)
						: $urandom_range(4, 400);
				else
					base = $urandom_range(1, 12);
				jit   = base / 32;
				teeth = (long_wheel && seq == 1) ? 280 : $urandom_range(2, 24);
				for (int i = 0; i < teeth; i++) begin
					dur = base - jit + $urandom_range(0, 2 * jit);
					toggle_level(t, lvl, dur);
					sent++;
					// same level again, ignored by the block
					if ($urandom_range(0, 9) == 0)
						send_sample(t + $urandom_range(0, dur / 2), lvl);
				end
				// missing tooth: normally two long segments, sometimes only one
				gap_segs = ($urandom_range(0, 7) == 0) ? 1 : 2;
				for (int i = 0; i < gap_segs; i++) begin
					dur = 2 * base + $urandom_range(0, base);
					toggle_level(t, lvl, dur);
					sent++;
				end
				seq++;
			end else if (kind < 17) begin
				dur = $urandom_range(0, cur_max_dur + 8);
				toggle_level(t, lvl, dur);
				sent++;
			end else if (kind == 17) begin
				// zero-length segment
				toggle_level(t, lvl, '0);
				sent++;
			end else begin
				// time jump, usually far too long
				t   = $urandom();
				lvl = 1'($urandom_range(0, 1));
				send_sample(t, lvl);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Edge sink with random stalls and one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall;
		int          hold;
		bit          took;
		stall = 0;
		hold  = 0;
		edges_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			took = edges_if.valid && edges_if.ready;
			if (took)
				sb.check_edge(edges_if.edge_index, edges_if.edge_time);
			if (hold_req && took) begin
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				edges_if.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				edges_if.ready <= 1'b0;
			end else if (!no_idling && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 18) - 1;
				edges_if.ready <= 1'b0;
			end else begin
				edges_if.ready <= 1'b1;
			end
		end
	end

	// watchdog: no beat on any channel for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((samples_if.valid && samples_if.ready) || (edges_if.valid && edges_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cycles);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		no_idling            = 1'b0;
		hold_req             = 1'b0;
		cur_max_dur          = MAX_DUR_RESET;
		arst_n               <= 1'b0;
		samples_if.valid     <= 1'b0;
		samples_if.timestamp <= '0;
		samples_if.level     <= 1'b0;
		cfg_if.valid         <= 1'b0;
		cfg_if.max_duration  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at the reset setting
		write_max_duration(MAX_DUR_RESET);
		send_sample(32'hFFFF_FF00, 1'b0); // first sample only records
		send_sample(32'hFFFF_FF20, 1'b0); // unchanged level
		send_sample(32'hFFFF_FF64, 1'b1); // history filling
		send_sample(32'hFFFF_FFC8, 1'b0);
		send_sample(32'h0000_0030, 1'b1); // segment across the time wrap
		send_sample(32'h0000_0092, 1'b0); // history full, no gap, not synced
		send_sample(32'h0000_018C, 1'b1);
		send_sample(32'h0000_0290, 1'b0); // gap -> index 0
		send_sample(32'h0000_02F4, 1'b1); // index 1
		send_sample(32'h0000_0358, 1'b0); // index 2
		send_sample(32'h0000_0358, 1'b1); // zero duration clears
		send_sample(32'hFFFF_FFFF, 1'b1); // first again, all-ones time
		send_sample(32'h0000_0000, 1'b0); // shortest segment
		send_sample(32'h0000_7FFF, 1'b1); // exactly max_duration clears
		send_sample(32'h0000_8000, 1'b0);
		send_sample(32'h0000_FFFE, 1'b1); // one below max_duration
		drain_block();

		// full scale, receiver holds off once the wheel is synced
		hold_req = 1'b1;
		run_phase(130, 1'b0);
		drain_block();
		hold_req = 1'b0;

		// every change clears
		write_max_duration('0);
		no_idling = ($urandom_range(0, 3) == 0);
		run_phase(60, 1'b0);
		drain_block();

		write_max_duration(DUR_W'($urandom_range(64, 32767)));
		no_idling = ($urandom_range(0, 3) == 0);
		run_phase(130, 1'b0);
		drain_block();

		write_max_duration(15'd1);
		no_idling = 1'b0;
		run_phase(40, 1'b0);
		drain_block();

		// long tooth run to saturate the index
		write_max_duration(MAX_DUR_RESET);
		no_idling = ($urandom_range(0, 3) == 0);
		run_phase(330, 1'b1);
		drain_block();

		write_max_duration(DUR_W'($urandom_range(2, 63)));
		no_idling = 1'b0;
		run_phase(60, 1'b0);
		drain_block();

		// closing stretch without idling
		write_max_duration(MAX_DUR_RESET);
		no_idling = 1'b1;
		run_phase(150, 1'b0);
		drain_block();

		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
